### design/lsms_pkg.sv
// ----------------------------------------------------------------------------
// lsms_pkg: shared types for the lifo stack with min search
// Request codes, cell control group and the compare token that travels
// down the row of cells.
// ----------------------------------------------------------------------------
package lsms_pkg;

  // request codes carried in s_tuser
  typedef enum logic [2:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_PEEK    = 3'd2,
    MODE_MIN     = 3'd3,
    MODE_SEARCH  = 3'd4,
    MODE_REVERSE = 3'd5,
    MODE_CLEAR   = 3'd6
  } mode_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_REV,
    ST_COMMIT,
    ST_DONE
  } state_t;

  // word returned on a refused push or on a pop, peek or min of an empty stack
  localparam logic [31:0] ERR_WORD = 32'hFFFF_FFFF;

  // control broadcast to every cell
  typedef struct packed {
    logic shift_down;  // push: each entry moves one place away from the top
    logic shift_up;    // pop: each entry moves towards the top
    logic rev_step;    // reverse step: top entry enters the auxiliary row, each entry moves towards the top
    logic rev_commit;  // reverse: auxiliary row replaces the entries
  } cell_ctl_t;

  // running minimum and search hit handed from cell to cell
  typedef struct packed {
    logic               any;
    logic signed [31:0] min;
    logic               found;
  } tok_t;

endpackage

### design/lsms_cell.sv
// ----------------------------------------------------------------------------
// lsms_cell: one place of the stack
// Holds one entry and one auxiliary word, shifts with its neighbours and
// folds its entry into the compare token on its way down the row.
// ----------------------------------------------------------------------------
module lsms_cell
  import lsms_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic               held,
  input  logic signed [31:0] target,
  input  logic signed [31:0] up_entry,
  input  logic signed [31:0] down_entry,
  input  logic signed [31:0] up_aux,
  input  tok_t               tok_in,
  output logic signed [31:0] entry,
  output logic signed [31:0] aux,
  output tok_t               tok_out
);

  tok_t tok_next;

  // entry shifting and reverse commit
  always_ff @(posedge clk) begin
    if (ctl.shift_down) begin
      entry <= up_entry;
    end else if (ctl.shift_up || ctl.rev_step) begin
      entry <= down_entry;
    end else if (ctl.rev_commit) begin
      entry <= aux;
    end
  end

  // auxiliary row fills from the top during a reverse
  always_ff @(posedge clk) begin
    if (ctl.rev_step) begin
      aux <= up_aux;
    end
  end

  // fold this entry into the token when it is held
  always_comb begin
    tok_next = tok_in;
    if (held) begin
      if (!tok_in.any || (entry < tok_in.min)) begin
        tok_next.min = entry;
      end
      tok_next.any   = 1'b1;
      tok_next.found = tok_in.found | (entry == target);
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule

### design/lifo_stack_with_min_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_min_search: bounded lifo of signed words with min search
// Row of DEPTH cells, top in cell 0, with a small controller in front.
// ----------------------------------------------------------------------------
// One transaction at a time. Push, pop, peek, clear, the unused code, refused
// requests, requests on an empty stack and reverse of a single entry go from
// acceptance straight to the done state. Minimum and search on a non-empty
// stack walk first: a compare token moves down the row of cells one cell per
// cycle. Reverse of two or more entries steps first: the entries leave the
// top one per cycle into an auxiliary row, which is then copied back in the
// commit state. A new request is taken as soon as the previous one has
// produced its result, even while that result still waits in the output
// register.
// s_tuser carries the request code, s_tdata the operand; results report the
// data word, found, error, empty flag and the fill masked to 5 bits.
module lifo_stack_with_min_search
  import lsms_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // operand[31:0]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // data[31:0], found[32], error[33],
                                 // is_empty[34], fill[39:35]
);

  localparam int CW = $clog2(DEPTH + 1);

  state_t             state, state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      step;
  mode_t              op;
  logic signed [31:0] target;
  logic signed [31:0] res_data;
  logic               res_found;
  logic               res_error;
  logic signed [31:0] res_data_next;
  logic               res_found_next;
  logic               res_error_next;
  logic               accept;
  logic               full;
  logic               empty;
  logic               out_free;
  mode_t              mode_in;
  cell_ctl_t          ctl;

  logic signed [31:0] entry [DEPTH];
  logic signed [31:0] aux   [DEPTH];
  tok_t               tok   [DEPTH];
  logic [DEPTH-1:0]   held;

  assign mode_in  = mode_t'(s_tuser);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode_in)
            MODE_MIN, MODE_SEARCH: state_next = empty ? ST_DONE : ST_WALK;
            MODE_REVERSE: state_next = (count > CW'(1)) ? ST_REV : ST_DONE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        if (step == CW'(DEPTH)) state_next = ST_DONE;
      end
      ST_REV: begin
        if (step == count - CW'(1)) state_next = ST_COMMIT;
      end
      ST_COMMIT: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    ctl      = '0;
    s_tready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode_in == MODE_PUSH) && !full) ctl.shift_down = 1'b1;
        if (accept && (mode_in == MODE_POP) && !empty) ctl.shift_up = 1'b1;
      end
      ST_REV:    ctl.rev_step   = 1'b1;
      ST_COMMIT: ctl.rev_commit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      case (mode_in)
        MODE_PUSH:  if (!full) count <= count + CW'(1);
        MODE_POP:   if (!empty) count <= count - CW'(1);
        MODE_CLEAR: count <= '0;
        default: ;
      endcase
    end
  end

  // walk and reverse step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (accept) begin
      step <= '0;
    end else if ((state == ST_WALK) || (state == ST_REV)) begin
      step <= step + CW'(1);
    end
  end

  // result word for the request in hand
  always_comb begin
    res_data_next  = res_data;
    res_found_next = res_found;
    res_error_next = res_error;
    if (accept) begin
      res_data_next  = '0;
      res_found_next = 1'b0;
      res_error_next = 1'b0;
      case (mode_in)
        MODE_PUSH: begin
          if (full) begin
            res_data_next  = ERR_WORD;
            res_error_next = 1'b1;
          end
        end
        MODE_POP, MODE_PEEK, MODE_MIN: begin
          if (empty) begin
            res_data_next  = ERR_WORD;
            res_error_next = 1'b1;
          end else if (mode_in != MODE_MIN) begin
            res_data_next = entry[0];
          end
        end
        default: ;
      endcase
    end else if ((state == ST_WALK) && (step == CW'(DEPTH))) begin
      if (op == MODE_MIN) begin
        res_data_next = tok[DEPTH-1].min;
      end else begin
        res_found_next = tok[DEPTH-1].found;
      end
    end
  end

  // request latch and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= mode_in;
      target <= s_tdata;
    end
    res_data  <= res_data_next;
    res_found <= res_found_next;
    res_error <= res_error_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata <= {5'(count), empty, res_error, res_found, res_data};
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] up_entry;
    logic signed [31:0] down_entry;
    logic signed [31:0] up_aux;
    tok_t               tok_in;

    assign held[i] = (count > CW'(i));

    if (i == 0) begin : g_top
      assign up_entry = s_tdata;
      assign up_aux   = entry[0];
      assign tok_in   = '0;
    end else begin : g_mid
      assign up_entry = entry[i-1];
      assign up_aux   = aux[i-1];
      assign tok_in   = tok[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign down_entry = entry[i];
    end else begin : g_inner
      assign down_entry = entry[i+1];
    end

    lsms_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .held       (held[i]),
      .target     (target),
      .up_entry   (up_entry),
      .down_entry (down_entry),
      .up_aux     (up_aux),
      .tok_in     (tok_in),
      .entry      (entry[i]),
      .aux        (aux[i]),
      .tok_out    (tok[i])
    );
  end

endmodule

### design/lsms_checker.sv
// ----------------------------------------------------------------------------
// lsms_checker: port-level checks for the lifo stack with min search
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module lsms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // a stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // an error result always carries the error word
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> (m_tdata[31:0] == 32'hFFFF_FFFF))
    else $error("error result without error word");

  // a search hit is never an error and carries a zero word
  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> !m_tdata[33] && (m_tdata[31:0] == 32'd0))
    else $error("search hit with error or data");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented after reset");

endmodule

bind lifo_stack_with_min_search lsms_checker u_lsms_checker (.*);
